// ===== hw/rtl/bfps_pkg.sv =====
// Shared types and codes for the byte FIFO with pattern search.
`timescale 1ns / 1ps
package bfps_pkg;
	// store capacity; the request and response field widths are sized for it
	localparam int DEPTH = 256;

	typedef enum logic [2:0] {
		OP_PUT    = 3'd0,
		OP_REMOVE = 3'd1,
		OP_CLEAR  = 3'd2,
		OP_READ   = 3'd3,
		OP_FINDB  = 3'd4,
		OP_FINDP  = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_MISS     = 2'd2
	} status_t;
endpackage

// ===== hw/rtl/byte_fifo_with_pattern_search.sv =====
// Top level: byte FIFO with byte and pattern search, one shared byte compare.
`timescale 1ns / 1ps
// Put, remove, clear: result valid in the cycle after the request is taken. An
// in-range read passes through issue, RAM wait and compare states before done.
// Find byte / find pattern: each byte compared passes through issue, RAM wait and
// compare on the single RAM read port; a pattern search compares each window byte
// by byte, restarting at the next window on a mismatch. One request at a time.
// Reset (arst_n low) empties the FIFO; store contents are not cleared.
module byte_fifo_with_pattern_search #(
	parameter int MAX_PATTERN = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// op[2:0], data_byte[10:3], amount[19:11], start_offset[27:20],
	// match_byte[35:28], pattern[99:36], zero fill to 104
	input  logic [103:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// status[1:0], position[9:2], read_byte[17:10], fill_level[26:18], zero fill
	output logic [31:0]  m_tdata
);
	localparam int DEPTH = bfps_pkg::DEPTH;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_ISSUE, S_WAIT, S_CMP, S_DONE
	} state_t;

	state_t          state_q;
	logic [AW-1:0]   head_q;
	logic [CW-1:0]   fill_q;
	logic [2:0]      op_q;
	logic [8:0]      amount_q;
	logic [7:0]      match_q;
	logic [63:0]     pattern_q;
	logic [CW:0]     pos_q;     // candidate window start
	logic [3:0]      k_q;       // byte within window
	logic [1:0]      status_q;
	logic [7:0]      position_q;
	logic [7:0]      rbyte_q;

	// request fields
	logic [2:0]  in_op;
	logic [7:0]  in_data;
	logic [8:0]  in_amount;
	logic [7:0]  in_start;
	assign in_op     = s_tdata[2:0];
	assign in_data   = s_tdata[10:3];
	assign in_amount = s_tdata[19:11];
	assign in_start  = s_tdata[27:20];

	// RAM
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [7:0]    ram_rdata;
	logic [CW:0]   off;
	logic [CW:0]   raddr_w;
	assign off       = pos_q + (CW+1)'(k_q);
	assign raddr_w   = (CW+1)'(head_q) + off;
	assign ram_raddr = raddr_w[AW-1:0];
	assign ram_we    = s_tvalid && s_tready && (in_op == bfps_pkg::OP_PUT)
		&& (fill_q < CW'(DEPTH));
	assign ram_waddr = AW'((CW+1)'(head_q) + (CW+1)'(fill_q));

	bfps_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(in_data),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	// shared compare: the byte sought this step
	logic [7:0] want;
	logic [2:0] kidx;
	assign kidx = k_q[2:0];
	assign want = (op_q == bfps_pkg::OP_FINDB) ? match_q : pattern_q[8*kidx +: 8];

	logic [3:0]  len;
	logic        eq;
	logic        win_fits;
	assign len      = (op_q == bfps_pkg::OP_FINDB) ? 4'd1 : amount_q[3:0];
	assign eq       = (ram_rdata == want);
	assign win_fits = (pos_q + (CW+1)'(len)) <= (CW+1)'(fill_q);

	logic [CW-1:0] rm;
	assign rm = (in_amount > 9'(fill_q)) ? fill_q : CW'(in_amount);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_DONE);
	assign m_tdata  = {5'd0, 9'(fill_q), rbyte_q, position_q, status_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			head_q     <= '0;
			fill_q     <= '0;
			op_q       <= '0;
			amount_q   <= '0;
			match_q    <= '0;
			pattern_q  <= '0;
			pos_q      <= '0;
			k_q        <= '0;
			status_q   <= '0;
			position_q <= '0;
			rbyte_q    <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						op_q       <= in_op;
						amount_q   <= in_amount;
						match_q    <= s_tdata[35:28];
						pattern_q  <= s_tdata[99:36];
						pos_q      <= (CW+1)'(in_start);
						k_q        <= '0;
						position_q <= '0;
						rbyte_q    <= '0;
						unique case (in_op)
							bfps_pkg::OP_PUT: begin
								state_q <= S_DONE;
								if (fill_q < CW'(DEPTH)) begin
									fill_q   <= fill_q + 1'b1;
									status_q <= bfps_pkg::ST_OK;
								end else
									status_q <= bfps_pkg::ST_OVERFLOW;
							end
							bfps_pkg::OP_REMOVE: begin
								head_q   <= AW'((CW+1)'(head_q) + (CW+1)'(rm));
								fill_q   <= fill_q - rm;
								status_q <= bfps_pkg::ST_OK;
								state_q  <= S_DONE;
							end
							bfps_pkg::OP_CLEAR: begin
								head_q   <= '0;
								fill_q   <= '0;
								status_q <= bfps_pkg::ST_OK;
								state_q  <= S_DONE;
							end
							bfps_pkg::OP_READ: begin
								if (CW'(in_start) < fill_q) begin
									status_q <= bfps_pkg::ST_OK;
									state_q  <= S_ISSUE;
								end else begin
									status_q <= bfps_pkg::ST_MISS;
									state_q  <= S_DONE;
								end
							end
							bfps_pkg::OP_FINDB: begin
								status_q <= bfps_pkg::ST_MISS;
								state_q  <= S_ISSUE;
							end
							bfps_pkg::OP_FINDP: begin
								status_q <= bfps_pkg::ST_MISS;
								if (in_amount >= 9'd1 && in_amount <= 9'(MAX_PATTERN))
									state_q <= S_ISSUE;
								else
									state_q <= S_DONE;
							end
							default: begin
								status_q <= bfps_pkg::ST_MISS;
								state_q  <= S_DONE;
							end
						endcase
					end
				end
				S_ISSUE: begin
					// address presented this cycle; data valid next
					if (op_q != bfps_pkg::OP_READ && !win_fits) state_q <= S_DONE;
					else state_q <= S_WAIT;
				end
				S_WAIT: state_q <= S_CMP;
				S_CMP: begin
					if (op_q == bfps_pkg::OP_READ) begin
						rbyte_q <= ram_rdata;
						state_q <= S_DONE;
					end else if (eq && (k_q + 4'd1 == len)) begin
						status_q   <= bfps_pkg::ST_OK;
						position_q <= pos_q[7:0];
						state_q    <= S_DONE;
					end else if (eq) begin
						k_q     <= k_q + 4'd1;
						state_q <= S_ISSUE;
					end else begin
						k_q     <= '0;
						pos_q   <= pos_q + 1'b1;
						state_q <= S_ISSUE;
					end
				end
				S_DONE: if (m_tready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(DEPTH)) else $error("fill above depth");
	a_idle_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |=> $stable(fill_q)) else $error("fill moved while busy");
	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		k_q < 4'(MAX_PATTERN)) else $error("window index overrun");
	a_ok_found: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && op_q == bfps_pkg::OP_FINDB && status_q == bfps_pkg::ST_OK)
		|-> (9'(position_q) < 9'(fill_q))) else $error("found past fill");
endmodule

// ===== hw/rtl/bfps_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module bfps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== tb/byte_fifo_with_pattern_search_test.sv =====
// Self-checking testbench for the byte FIFO with byte and pattern search.
`timescale 1ns / 1ps
module byte_fifo_with_pattern_search_test;
	localparam int DEPTH       = bfps_pkg::DEPTH;
	localparam int MAX_PATTERN = 8;
	localparam int IDLE_LIMIT  = 20000;  // watchdog bound, sized for the worst search
	localparam int HOLD_CYCLES = 400;

	// One request as it travels on s_tdata.
	typedef struct packed {
		logic [63:0] pattern;
		logic [7:0]  match_byte;
		logic [7:0]  start_offset;
		logic [8:0]  amount;
		logic [7:0]  data_byte;
		logic [2:0]  op;
	} request_t;

	// One response as it travels on m_tdata.
	typedef struct packed {
		logic [8:0] fill_level;
		logic [7:0] read_byte;
		logic [7:0] position;
		logic [1:0] status;
	} response_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	// op, data_byte, amount, start_offset, match_byte, pattern (low bit up), zero fill
	logic [103:0] s_tdata = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	// status, position, read_byte, fill_level (low bit up), zero fill
	logic [31:0]  m_tdata;

	byte_fifo_with_pattern_search #(.MAX_PATTERN(MAX_PATTERN)) DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow of the FIFO contents, kept by the predictor.
	logic [7:0] shadow_store [DEPTH];
	int unsigned shadow_head;
	int unsigned shadow_fill;

	request_t  pending_requests [$];
	response_t expected_responses [$];
	int  error_count;
	bit  hold_off;      // set by the stimulus process for the back-pressure stretch
	int  idle_cycles;
	int  sent_count;
	bit  in_taken = 1'b0;   // request accepted at the last rising edge
	bit  out_taken = 1'b0;  // response accepted at the last rising edge

	function automatic logic [7:0] shadow_byte(int unsigned off);
		return shadow_store[(shadow_head + off) % DEPTH];
	endfunction

	// Apply one request to the shadow FIFO and compute its response.
	function automatic response_t fifo_apply(request_t rq);
		response_t rs;
		int unsigned amt;
		bit hit;
		rs = '0;
		case (rq.op)
			bfps_pkg::OP_PUT: begin
				if (shadow_fill < DEPTH) begin
					shadow_store[(shadow_head + shadow_fill) % DEPTH] = rq.data_byte;
					shadow_fill++;
				end else
					rs.status = bfps_pkg::ST_OVERFLOW;
			end
			bfps_pkg::OP_REMOVE: begin
				amt = (rq.amount > shadow_fill) ? shadow_fill : rq.amount;
				shadow_head = (shadow_head + amt) % DEPTH;
				shadow_fill -= amt;
			end
			bfps_pkg::OP_CLEAR: begin
				shadow_head = 0;
				shadow_fill = 0;
			end
			bfps_pkg::OP_READ: begin
				if (rq.start_offset < shadow_fill)
					rs.read_byte = shadow_byte(rq.start_offset);
				else
					rs.status = bfps_pkg::ST_MISS;
			end
			bfps_pkg::OP_FINDB: begin
				rs.status = bfps_pkg::ST_MISS;
				for (int unsigned p = rq.start_offset; p < shadow_fill; p++) begin
					if (shadow_byte(p) == rq.match_byte) begin
						rs.status = bfps_pkg::ST_OK;
						rs.position = p[7:0];
						break;
					end
				end
			end
			bfps_pkg::OP_FINDP: begin
				rs.status = bfps_pkg::ST_MISS;
				if (rq.amount >= 1 && rq.amount <= MAX_PATTERN) begin
					for (int unsigned p = rq.start_offset; p + rq.amount <= shadow_fill;
							p++) begin
						hit = 1'b1;
						for (int unsigned i = 0; i < rq.amount; i++)
							if (shadow_byte(p + i) != rq.pattern[8*i +: 8])
								hit = 1'b0;
						if (hit) begin
							rs.status = bfps_pkg::ST_OK;
							rs.position = p[7:0];
							break;
						end
					end
				end
			end
			default: rs.status = bfps_pkg::ST_MISS;
		endcase
		rs.fill_level = shadow_fill[8:0];
		return rs;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $time);
		error_count++;
	endtask

	// Driver: one request at a time off the queue, with a random gap after each one is taken.
	int send_gap = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_taken) begin
				in_taken = 1'b0;
				void'(pending_requests.pop_front());
				sent_count++;
				send_gap = $urandom_range(0, 12);
				if ($urandom_range(0, 3) == 0)
					send_gap = 0;
			end
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (pending_requests.size() > 0) begin
				s_tdata <= {4'd0, pending_requests[0]};
				s_tvalid <= 1'b1;
			end else
				s_tvalid <= 1'b0;
		end
	end

	// Predict at acceptance, so the shadow follows the order the block sees.
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			expected_responses.push_back(fifo_apply(request_t'(s_tdata[99:0])));
			in_taken = 1'b1;
		end
	end

	// Receiver readiness: random stalls, plus the long hold-off stretch.
	int recv_gap = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_taken) begin
				out_taken = 1'b0;
				recv_gap = $urandom_range(0, 12) * $urandom_range(0, 1);
			end
			if (hold_off)
				m_tready <= 1'b0;
			else if (recv_gap > 0) begin
				recv_gap--;
				m_tready <= 1'b0;
			end else
				m_tready <= 1'b1;
		end
	end

	// Monitor: compare each response with the oldest prediction.
	always @(posedge clk) begin
		response_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			out_taken = 1'b1;
			got = response_t'(m_tdata[26:0]);
			if (expected_responses.size() == 0)
				report_mismatch("unexpected response", 1, 0);
			else begin
				want = expected_responses.pop_front();
				if (got.status != want.status)
					report_mismatch("status", got.status, want.status);
				if (got.position != want.position)
					report_mismatch("position", got.position, want.position);
				if (got.read_byte != want.read_byte)
					report_mismatch("read_byte", got.read_byte, want.read_byte);
				if (got.fill_level != want.fill_level)
					report_mismatch("fill_level", got.fill_level, want.fill_level);
			end
		end
	end

	// Watchdog on cycles with no handshake on either side.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT + HOLD_CYCLES) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic request_t make_request(bfps_pkg::op_t op, int db, int amt, int so,
			int mb, logic [63:0] pat);
		request_t rq;
		rq.op = op;
		rq.data_byte = db[7:0];
		rq.amount = amt[8:0];
		rq.start_offset = so[7:0];
		rq.match_byte = mb[7:0];
		rq.pattern = pat;
		return rq;
	endfunction

	function automatic logic [63:0] random_pattern();
		return {$urandom(), $urandom()};
	endfunction

	// Random request; bytes drawn from 0 to alpha, so a small alpha makes searches hit often.
	// Reads and searches only reach held bytes or report out of range, so a
	// never-written entry is never observed.
	function automatic request_t random_request(int alpha);
		request_t rq;
		int sel;
		int len;
		sel = $urandom_range(0, 99);
		rq = make_request(bfps_pkg::OP_PUT, $urandom_range(0, alpha), $urandom_range(0, 511),
			$urandom_range(0, 255), $urandom_range(0, alpha), random_pattern());
		if (sel < 40)
			rq.op = bfps_pkg::OP_PUT;
		else if (sel < 47) begin
			rq.op = bfps_pkg::OP_REMOVE;
			rq.amount = ($urandom_range(0, 5) == 0) ? 9'($urandom_range(0, 511))
				: 9'($urandom_range(0, 6));
		end else if (sel < 49)
			rq.op = bfps_pkg::OP_CLEAR;
		else if (sel < 60)
			rq.op = bfps_pkg::OP_READ;
		else if (sel < 75) begin
			rq.op = bfps_pkg::OP_FINDB;
			rq.start_offset = 8'($urandom_range(0, 40));
		end else if (sel < 97) begin
			rq.op = bfps_pkg::OP_FINDP;
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511)
				: $urandom_range(1, MAX_PATTERN);
			rq.amount = len[8:0];
			rq.start_offset = 8'($urandom_range(0, 40));
			// bytes up to alpha, with some noise bytes
			for (int i = 0; i < 8; i++)
				rq.pattern[8*i +: 8] = ($urandom_range(0, 3) == 0)
					? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, alpha));
		end else
			rq.op = bfps_pkg::op_t'($urandom_range(6, 7));
		return rq;
	endfunction

	initial begin
		error_count = 0;
		hold_off = 0;
		sent_count = 0;
		idle_cycles = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: extremes and every special case.
		pending_requests.push_back(make_request(bfps_pkg::OP_READ, 0, 0, 0, 0, '0));
		pending_requests.push_back(make_request(bfps_pkg::OP_FINDB, 0, 0, 0, 0, '0));
		pending_requests.push_back(make_request(bfps_pkg::OP_REMOVE, 0, 511, 0, 0, '0));
		pending_requests.push_back(make_request(bfps_pkg::OP_PUT, 8'h00, 0, 0, 0, '0));
		pending_requests.push_back(make_request(bfps_pkg::OP_PUT, 8'hFF, 0, 0, 0, '0));
		pending_requests.push_back(make_request(bfps_pkg::OP_PUT, 8'hA5, 0, 0, 0, '0));
		pending_requests.push_back(make_request(bfps_pkg::OP_PUT, 8'h5A, 0, 0, 0, '0));
		pending_requests.push_back(make_request(bfps_pkg::OP_READ, 0, 0, 3, 0, '0)); // last
		pending_requests.push_back(make_request(bfps_pkg::OP_READ, 0, 0, 4, 0, '0)); // past
		pending_requests.push_back(make_request(bfps_pkg::OP_FINDB, 0, 0, 0, 8'hFF, '0));
		pending_requests.push_back(make_request(bfps_pkg::OP_FINDB, 0, 0, 255, 8'hFF, '0));
		// match ending exactly at the last held byte
		pending_requests.push_back(make_request(bfps_pkg::OP_FINDP, 0, 2, 0, 0, 64'h5AA5));
		pending_requests.push_back(make_request(bfps_pkg::OP_FINDP, 0, 4, 0, 0,
			64'h5AA5FF00));
		pending_requests.push_back(make_request(bfps_pkg::OP_FINDP, 0, 5, 0, 0,
			64'h5AA5FF00));
		pending_requests.push_back(make_request(bfps_pkg::OP_FINDP, 0, 0, 0, 0, '0));
		pending_requests.push_back(make_request(bfps_pkg::OP_FINDP, 0, 9, 0, 0, '1));
		pending_requests.push_back(make_request(bfps_pkg::OP_FINDP, 0, 1, 255, 0, '1));
		pending_requests.push_back(make_request(bfps_pkg::op_t'(3'd6), 0, 0, 0, 0, '0));
		pending_requests.push_back(make_request(bfps_pkg::op_t'(3'd7), 8'hFF, 511, 255,
			8'hFF, '1));
		pending_requests.push_back(make_request(bfps_pkg::OP_REMOVE, 0, 1, 0, 0, '0));
		pending_requests.push_back(make_request(bfps_pkg::OP_CLEAR, 0, 0, 0, 0, '0));

		// Fill to capacity and beyond while the receiver holds off, so the
		// block stalls its input; then overflow and reads at the top offset.
		for (int i = 0; i < DEPTH + 3; i++)
			pending_requests.push_back(make_request(bfps_pkg::OP_PUT,
				$urandom_range(0, 255), 0, 0, 0, '0));
		hold_off = 1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off = 0;
		pending_requests.push_back(make_request(bfps_pkg::OP_READ, 0, 0, 255, 0, '0));
		pending_requests.push_back(make_request(bfps_pkg::OP_FINDP, 0, 8, 200, 0,
			random_pattern()));
		pending_requests.push_back(make_request(bfps_pkg::OP_REMOVE, 0, 256, 0, 0, '0));

		// Random part: wrap-around is reached through puts and removes.
		for (int i = 0; i < 1250; i++)
			pending_requests.push_back(random_request((i % 300 < 150) ? 3 : 255));

		wait (pending_requests.size() == 0);
		wait (expected_responses.size() == 0);
		repeat (50) @(posedge clk);
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
